### rtl/fdsc_pkg.sv
// Package for the frame deframer with sequence check.
// Holds the result type, register indexes and reset constants; no dependencies.
`timescale 1ns / 1ps

package fdsc_pkg;

	localparam int BYTE_W     = 8;
	localparam int SIZE_W     = 6;
	localparam int SEQ_W      = 4;
	localparam int TYPE_W     = 6;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam int OUT_DATA_W = BYTE_W + TYPE_W + SEQ_W + SIZE_W;

	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEQ    = CFG_IDX_W'(1);

	localparam logic [BYTE_W-1:0] START_MARKER_RST = BYTE_W'(126);
	localparam logic [SEQ_W-1:0]  FIRST_SEQ_RST    = SEQ_W'(0);

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
		logic [TYPE_W-1:0] frame_type;
		logic [SEQ_W-1:0]  frame_seq;
		logic [SIZE_W-1:0] frame_size;
		logic              last;
	} result_t;

endpackage

### rtl/fdsc_parser.sv
// Frame parser: hunts for the start marker, decodes the header, keeps or drops frames.
// Also holds the configuration registers. Depends on fdsc_pkg.
`timescale 1ns / 1ps

module fdsc_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic [fdsc_pkg::BYTE_W-1:0]        rx_byte,
	input  logic                               cfg_we,
	input  logic [fdsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fdsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               res_valid,
	output fdsc_pkg::result_t                  res
);
	import fdsc_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HDR1,
		PH_HDR2,
		PH_DATA,
		PH_PARITY
	} phase_t;

	phase_t            phase_q;
	logic [SIZE_W-1:0] size_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TYPE_W-1:0] type_q;
	logic [SIZE_W-1:0] left_q;
	logic              keep_q;
	logic [SEQ_W-1:0]  exp_seq_q;
	logic [BYTE_W-1:0] marker_q;

	logic [SEQ_W-1:0]  hdr_seq;
	logic [SIZE_W-1:0] left_dec;

	assign hdr_seq  = {seq_q[3:2], rx_byte[7:6]};
	assign left_dec = left_q - SIZE_W'(1);

	always_comb begin
		res_valid      = en && keep_q && (phase_q == PH_DATA || phase_q == PH_PARITY);
		res.kind       = (phase_q == PH_PARITY) ? KIND_END : KIND_DATA;
		res.data_byte  = rx_byte;
		res.frame_type = type_q;
		res.frame_seq  = seq_q;
		res.frame_size = size_q;
		res.last       = (phase_q == PH_PARITY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			size_q    <= '0;
			seq_q     <= '0;
			type_q    <= '0;
			left_q    <= '0;
			keep_q    <= 1'b0;
			exp_seq_q <= FIRST_SEQ_RST;
			marker_q  <= START_MARKER_RST;
		end else begin
			if (en) begin
				unique case (phase_q)
					PH_HUNT: begin
						if (rx_byte == marker_q) begin
							phase_q <= PH_HDR1;
						end
					end
					PH_HDR1: begin
						size_q  <= rx_byte[7:2];
						seq_q   <= {rx_byte[1:0], 2'b00};
						phase_q <= PH_HDR2;
					end
					PH_HDR2: begin
						seq_q   <= hdr_seq;
						type_q  <= rx_byte[5:0];
						keep_q  <= (hdr_seq == exp_seq_q);
						left_q  <= size_q;
						phase_q <= (size_q == '0) ? PH_PARITY : PH_DATA;
					end
					PH_DATA: begin
						left_q <= left_dec;
						if (left_dec == '0) begin
							phase_q <= PH_PARITY;
						end
					end
					PH_PARITY: begin
						if (keep_q) begin
							exp_seq_q <= exp_seq_q + SEQ_W'(1);
						end
						keep_q  <= 1'b0;
						phase_q <= PH_HUNT;
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
			if (cfg_we) begin
				if (cfg_index == REG_START_MARKER) begin
					marker_q <= cfg_data[BYTE_W-1:0];
				end else if (cfg_index == REG_FIRST_SEQ) begin
					exp_seq_q <= cfg_data[SEQ_W-1:0];
				end
			end
		end
	end

endmodule

### rtl/fdsc_out_reg.sv
// Result register toward the master-side stream.
// Loads one result item and holds it until taken. Depends on fdsc_pkg.
`timescale 1ns / 1ps

module fdsc_out_reg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  fdsc_pkg::result_t                     res,
	output logic                                  free,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [fdsc_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tlast,
	output logic                                  m_tuser
);
	import fdsc_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.frame_size, res_q.frame_seq, res_q.frame_type, res_q.data_byte};
	assign m_tlast  = res_q.last;
	assign m_tuser  = res_q.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule

### rtl/frame_deframer_seq_check.sv
// Top level of the start-marker frame deframer with sequence check.
// Instantiates fdsc_parser and fdsc_out_reg; depends on fdsc_pkg.
//
//   Channel  | Direction | Signals                                  | Carries
//   s_*      | in        | s_tvalid s_tready s_tdata[7:0]           | rx_byte
//   m_*      | out       | m_tvalid m_tready m_tdata m_tlast m_tuser | one result item
//   cfg_*    | in        | cfg_valid cfg_ready cfg_index cfg_data   | register write
//
// An item passes from acceptance through the input register and then the result register.
// One item is accepted per cycle while the result register is not stalled; the single parser state
// update per byte sets that rate. Reset is asynchronous and leaves the block hunting with
// the register reset values. A stalled result register holds the input register, which
// then stops acceptance. Configuration writes are always taken.
`timescale 1ns / 1ps

module frame_deframer_seq_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fdsc_pkg::BYTE_W-1:0]         s_tdata,   // rx_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fdsc_pkg::OUT_DATA_W-1:0]     m_tdata,   // data_byte, frame_type, frame_seq, frame_size
	output logic                                m_tlast,   // last
	output logic                                m_tuser,   // kind
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fdsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fdsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fdsc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              advance;
	logic              res_valid;
	result_t           res;

	assign advance   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	fdsc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.rx_byte   (byte_s1),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	fdsc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> m_tvalid)
		else $error("result item was not loaded into the output register");

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == KIND_END)))
		else $error("last flag and kind disagree");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost an item while stalled");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> !res_valid)
		else $error("parser produced a result without an item");

endmodule

### tb/tb_frame_deframer_seq_check.sv
// Self-checking testbench for frame_deframer_seq_check: directed table, then random frames.
// Mirrors the deframer in a behavioral predictor and compares every result item.
// Depends on fdsc_pkg and the frame_deframer_seq_check RTL.
`timescale 1ns / 1ps

module tb_frame_deframer_seq_check;
	import fdsc_pkg::*;

	localparam int                   LONG_HOLD  = 80;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(255);

	typedef enum logic [2:0] {ST_HUNT, ST_HDR1, ST_HDR2, ST_DATA, ST_PARITY} deframe_st_e;
	typedef enum bit {ROW_ITEM, ROW_CFG} row_op_e;

	typedef struct {
		row_op_e             op;
		logic [CFG_IDX_W-1:0] idx;
		logic [BYTE_W-1:0]   val;
		bit                  typed;
		bit                  has_res;
		result_t             res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	deframe_st_e       ph = ST_HUNT;
	logic [SIZE_W-1:0] hdr_size = '0;
	logic [SEQ_W-1:0]  hdr_seq = '0;
	logic [TYPE_W-1:0] hdr_type = '0;
	logic [SIZE_W-1:0] remain = '0;
	bit                keep = 1'b0;
	logic [SEQ_W-1:0]  want_seq = FIRST_SEQ_RST;
	logic [BYTE_W-1:0] marker = START_MARKER_RST;

	// Both queues are filled at the front and drained from the back.
	result_t  deframed_q[$];
	dir_row_t dir_tab[$];
	int       errors = 0;
	int       sent = 0;
	int       stall_left = 0;
	bit       quiet = 1'b0;
	bit       long_hold_req = 1'b0;
	bit       long_hold_done = 1'b0;
	result_t  got, want;

	frame_deframer_seq_check i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("frame_deframer_seq_check test failed");
		$finish;
	end

	function automatic result_t out_item(logic k, logic [BYTE_W-1:0] b, logic [TYPE_W-1:0] t,
			logic [SEQ_W-1:0] s, logic [SIZE_W-1:0] z);
		result_t r;
		r = '{k, b, t, s, z, k};
		return r;
	endfunction

	function automatic dir_row_t item_row(logic [BYTE_W-1:0] b);
		dir_row_t row;
		row = '{ROW_ITEM, '0, b, 1'b0, 1'b0, '0};
		return row;
	endfunction

	function automatic dir_row_t typed_row(logic [BYTE_W-1:0] b, bit has, result_t r);
		dir_row_t row;
		row = '{ROW_ITEM, '0, b, 1'b1, has, r};
		return row;
	endfunction

	function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		dir_row_t row;
		row = '{ROW_CFG, idx, v, 1'b0, 1'b0, '0};
		return row;
	endfunction

	function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t r);
		bit emits;
		emits = 1'b0;
		r = '0;
		case (ph)
			ST_HDR1: begin
				hdr_size = b[7:2];
				hdr_seq = {b[1:0], 2'b00};
				ph = ST_HDR2;
			end
			ST_HDR2: begin
				hdr_seq[1:0] = b[7:6];
				hdr_type = b[5:0];
				keep = (hdr_seq == want_seq);
				remain = hdr_size;
				ph = (hdr_size == '0) ? ST_PARITY : ST_DATA;
			end
			ST_DATA: begin
				if (keep) begin
					r = out_item(KIND_DATA, b, hdr_type, hdr_seq, hdr_size);
					emits = 1'b1;
				end
				remain = remain - SIZE_W'(1);
				if (remain == '0)
					ph = ST_PARITY;
			end
			ST_PARITY: begin
				if (keep) begin
					r = out_item(KIND_END, b, hdr_type, hdr_seq, hdr_size);
					emits = 1'b1;
					want_seq = want_seq + SEQ_W'(1);
				end
				keep = 1'b0;
				ph = ST_HUNT;
			end
			default: begin
				ph = (b == marker) ? ST_HDR1 : ST_HUNT;
			end
		endcase
		return emits;
	endfunction

	task automatic push_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
			input bit has_res = 1'b0, input result_t fixed = '0);
		result_t r;
		bit      hit;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		hit = deframe_byte(b, r);
		sent++;
		if (typed) begin
			if (has_res)
				deframed_q.push_front(fixed);
		end else if (hit) begin
			deframed_q.push_front(r);
		end
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (idx == REG_START_MARKER)
			marker = v;
		else if (idx == REG_FIRST_SEQ)
			want_seq = v[SEQ_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Items that produce nothing can still sit in the pipeline once the queue is empty.
	task automatic flush_pipe();
		s_tvalid <= 1'b0;
		while (deframed_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_frame();
		logic [SIZE_W-1:0] size;
		logic [TYPE_W-1:0] ftype;
		logic [SEQ_W-1:0]  seq;
		int                len;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom_range(0, 255)));
		case ($urandom_range(0, 19))
			0:       size = '0;
			1:       size = '1;
			2, 3, 4: size = SIZE_W'($urandom_range(0, 63));
			default: size = SIZE_W'($urandom_range(1, 6));
		endcase
		seq = ($urandom_range(0, 3) != 0) ? want_seq : SEQ_W'($urandom_range(0, 15));
		ftype = TYPE_W'($urandom_range(0, 63));
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, size) : size + 1;
		push_byte(marker);
		push_byte({size, seq[3:2]});
		push_byte({seq[1:0], ftype});
		for (int n = 0; n < len; n++)
			push_byte(BYTE_W'($urandom_range(0, 255)));
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.data_byte = m_tdata[0 +: BYTE_W];
			got.frame_type = m_tdata[BYTE_W +: TYPE_W];
			got.frame_seq = m_tdata[BYTE_W + TYPE_W +: SEQ_W];
			got.frame_size = m_tdata[BYTE_W + TYPE_W + SEQ_W +: SIZE_W];
			got.last = m_tlast;
			if (deframed_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected item kind %0d byte %02h", $realtime, got.kind,
						got.data_byte);
			end else begin
				want = deframed_q.pop_back();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"%0t: mismatch expected kind %0d byte %02h type %0d seq %0d",
							" size %0d last %0d, got kind %0d byte %02h type %0d seq %0d",
							" size %0d last %0d"}, $realtime,
							want.kind, want.data_byte, want.frame_type, want.frame_seq,
							want.frame_size, want.last, got.kind, got.data_byte,
							got.frame_type, got.frame_seq, got.frame_size, got.last);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1'b1;
			stall_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		logic [BYTE_W-1:0]     mv;
		logic [CFG_DATA_W-1:0] sv;
		int                    target;
		dir_row_t              row;

		dir_tab.push_front(typed_row(8'h00, 1'b0, '0));
		dir_tab.push_front(item_row(8'h7E));
		dir_tab.push_front(item_row(8'h08));
		dir_tab.push_front(item_row(8'h3F));
		dir_tab.push_front(typed_row(8'hFF, 1'b1, out_item(KIND_DATA, 8'hFF, 6'd63, 4'd0, 6'd2)));
		dir_tab.push_front(typed_row(8'h00, 1'b1, out_item(KIND_DATA, 8'h00, 6'd63, 4'd0, 6'd2)));
		dir_tab.push_front(typed_row(8'hA5, 1'b1, out_item(KIND_END, 8'hA5, 6'd63, 4'd0, 6'd2)));
		// Empty payload, with the marker value arriving as the parity byte.
		dir_tab.push_front(item_row(8'h7E));
		dir_tab.push_front(item_row(8'h00));
		dir_tab.push_front(item_row(8'h40));
		dir_tab.push_front(typed_row(8'h7E, 1'b1, out_item(KIND_END, 8'h7E, 6'd0, 4'd1, 6'd0)));
		// Sequence 15 while 2 is expected: the frame is dropped.
		dir_tab.push_front(item_row(8'h7E));
		dir_tab.push_front(item_row(8'h07));
		dir_tab.push_front(item_row(8'hFF));
		dir_tab.push_front(item_row(8'h7E));
		dir_tab.push_front(item_row(8'h11));
		dir_tab.push_front(cfg_row(REG_START_MARKER, 8'hFF));
		dir_tab.push_front(cfg_row(REG_FIRST_SEQ, 8'h0F));
		dir_tab.push_front(cfg_row(REG_UNUSED, 8'h55));
		// Sequence 15 is kept and the expected sequence wraps to 0.
		dir_tab.push_front(item_row(8'hFF));
		dir_tab.push_front(item_row(8'h07));
		dir_tab.push_front(item_row(8'hFF));
		dir_tab.push_front(typed_row(8'h00, 1'b1, out_item(KIND_DATA, 8'h00, 6'd63, 4'd15, 6'd1)));
		dir_tab.push_front(typed_row(8'hFF, 1'b1, out_item(KIND_END, 8'hFF, 6'd63, 4'd15, 6'd1)));
		dir_tab.push_front(typed_row(8'h7E, 1'b0, '0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (dir_tab.size() != 0) begin
			row = dir_tab.pop_back();
			if (row.op == ROW_CFG) begin
				flush_pipe();
				set_reg(row.idx, row.val);
			end else begin
				push_byte(row.val, row.typed, row.has_res, row.res);
			end
		end

		for (int p = 0; p < 5; p++) begin
			quiet = (p == 4);
			if (p == 1)
				long_hold_req = 1'b1;
			target = sent + 106;
			while (sent < target)
				send_frame();
			// Odd phases stop inside a kept frame so the writes land mid-frame.
			if (p % 2 == 1) begin
				push_byte(marker);
				push_byte({6'd3, want_seq[3:2]});
				push_byte({want_seq[1:0], TYPE_W'($urandom_range(0, 63))});
			end
			flush_pipe();
			if (p < 4) begin
				case ($urandom_range(0, 3))
					0:       mv = 8'h00;
					1:       mv = 8'hFF;
					2:       mv = START_MARKER_RST;
					default: mv = BYTE_W'($urandom_range(0, 255));
				endcase
				case ($urandom_range(0, 2))
					0:       sv = 8'h00;
					1:       sv = 8'h0F;
					default: sv = CFG_DATA_W'($urandom_range(0, 255));
				endcase
				if (p == 0) begin
					mv = 8'h00;
					sv = 8'hF0;
				end
				if ($urandom_range(0, 1) == 0)
					set_reg(CFG_IDX_W'($urandom_range(REG_FIRST_SEQ + 1, 255)),
						CFG_DATA_W'($urandom_range(0, 255)));
				set_reg(REG_START_MARKER, mv);
				set_reg(REG_FIRST_SEQ, sv);
			end
		end

		if (errors == 0 && deframed_q.size() == 0)
			$display("frame_deframer_seq_check test passed");
		else
			$display("frame_deframer_seq_check test failed");
		$finish;
	end

endmodule

### files.f
rtl/fdsc_pkg.sv
rtl/fdsc_parser.sv
rtl/fdsc_out_reg.sv
rtl/frame_deframer_seq_check.sv
tb/tb_frame_deframer_seq_check.sv
